@@ rtl/gfr_pkg.sv @@
// ============================================================================
// gfr_pkg - shared types and constants for the gyro frame receiver
// Frame sync bytes, payload geometry, heading arithmetic constants, command
// codes and the control structs passed between the receiver's units.
// ============================================================================
package gfr_pkg;

    // frame layout
    localparam logic [7:0] SYNC_FIRST    = 8'hAA;
    localparam logic [7:0] SYNC_SECOND   = 8'h00;
    localparam int         PAYLOAD_BYTES = 12;
    localparam int         POS_W         = $clog2(PAYLOAD_BYTES + 1);

    // heading: ((36005 - raw) mod 36000) / 10
    localparam logic [16:0] ANGLE_BIAS    = 17'd36005;
    localparam logic [16:0] ANGLE_MODULUS = 17'd36000;
    // x / 10 == (x * 52429) >> 19 for every x below 36000
    localparam logic [16:0] DIV10_RECIP   = 17'd52429;
    localparam int          DIV10_SHIFT   = 19;
    localparam int          ANGLE_W       = 12;

    // offset value that means "latch on next good frame"
    localparam logic [15:0] OFFSET_ARMED = 16'h7FFF;

    // command codes
    localparam logic [1:0] CMD_RX     = 2'd0;
    localparam logic [1:0] CMD_REZERO = 2'd1;
    localparam logic [1:0] CMD_ARM    = 2'd2;

    typedef logic [PAYLOAD_BYTES-1:0][7:0] gfr_payload_t;

    // frame status from the deframer
    typedef struct packed {
        logic done;     // check word accepted this cycle
        logic sum_ok;   // check word matched the running sum
        logic at_last;  // next received word is the check word
    } gfr_frame_t;

    // odometer / offset commands
    typedef struct packed {
        logic rezero;
        logic arm;
    } gfr_cmd_t;

endpackage

@@ rtl/gfr_deframer.sv @@
// ============================================================================
// gfr_deframer - sync hunt and payload capture
// Hunts for the two sync words, stores 12 payload words, keeps the 8-bit
// running sum and flags frame completion with the check result.
// ============================================================================
module gfr_deframer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           command,
    input  logic [7:0]           rx_byte,
    output gfr_pkg::gfr_payload_t payload,
    output gfr_pkg::gfr_frame_t   frame
);
    import gfr_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT = 3'b001,
        ST_SYNC = 3'b010,
        ST_RECV = 3'b100
    } gfr_state_t;

    gfr_state_t       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    gfr_payload_t     payload_reg;
    logic             rx_go;
    logic             store_en;

    assign rx_go = accept && (command == CMD_RX);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        store_en    = 1'b0;
        frame.done  = 1'b0;
        frame.sum_ok = 1'b0;
        frame.at_last = (state_reg == ST_RECV) && (pos_reg == POS_W'(PAYLOAD_BYTES));
        if (rx_go)
        begin
            unique case (state_reg)
                ST_SYNC:
                begin
                    pos_next = '0;
                    if (rx_byte == SYNC_SECOND)
                    begin
                        state_next = ST_RECV;
                        sum_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
                ST_RECV:
                begin
                    if (pos_reg < POS_W'(PAYLOAD_BYTES))
                    begin
                        store_en = 1'b1;
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        frame.done   = 1'b1;
                        frame.sum_ok = (rx_byte == sum_reg);
                        state_next   = ST_HUNT;
                        pos_next     = '0;
                        sum_next     = '0;
                    end
                end
                default:
                begin
                    state_next = (rx_byte == SYNC_FIRST) ? ST_SYNC : ST_HUNT;
                end
            endcase
        end
    end

    assign payload       = payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            pos_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    // payload words, no reset
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            payload_reg[pos_reg[POS_W-1:0]] <= rx_byte;
        end
    end

endmodule

@@ rtl/gfr_angle.sv @@
// ============================================================================
// gfr_angle - heading in tenths of a degree
// Two registered steps from payload words 1 and 2: modular offset, then a
// reciprocal multiply for the divide by ten. Words 1 and 2 are stored ahead
// of words 3 to 11 and the check word, so the result is ready in time.
// ============================================================================
module gfr_angle
(
    input  logic                  clk,
    input  gfr_pkg::gfr_payload_t payload,
    output logic [gfr_pkg::ANGLE_W-1:0] angle
);
    import gfr_pkg::*;

    logic [15:0] raw;
    logic [16:0] shifted;
    logic [15:0] l_next, l_reg;
    logic [33:0] prod;
    logic [ANGLE_W-1:0] angle_reg;

    assign raw     = {payload[2], payload[1]};
    // 36005 - raw stays within 3238..68773, no wrap
    assign shifted = ANGLE_BIAS - {raw[15], raw};
    assign l_next  = (shifted >= ANGLE_MODULUS) ? 16'(shifted - ANGLE_MODULUS)
                                                : shifted[15:0];

    assign prod = {1'b0, l_reg} * DIV10_RECIP;

    always_ff @(posedge clk)
    begin
        l_reg     <= l_next;
        angle_reg <= prod[DIV10_SHIFT +: ANGLE_W];
    end

    assign angle = angle_reg;

endmodule

@@ rtl/gfr_decode.sv @@
// ============================================================================
// gfr_decode - frame decode and result register
// Odometer, acceleration words, offset latching and offset differences,
// written into the result register on each completed frame.
// ============================================================================
module gfr_decode
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  gfr_pkg::gfr_frame_t           frame,
    input  gfr_pkg::gfr_cmd_t             cmd,
    input  gfr_pkg::gfr_payload_t         payload,
    input  logic [gfr_pkg::ANGLE_W-1:0]   angle,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic                          checksum_ok,
    output logic [7:0]                    frame_tag,
    output logic signed [15:0]            rate,
    output logic [gfr_pkg::ANGLE_W-1:0]   angle_tenths,
    output logic signed [31:0]            odometer,
    output logic signed [15:0]            accel_x,
    output logic signed [15:0]            accel_y,
    output logic signed [15:0]            accel_z,
    output logic signed [15:0]            diff_x,
    output logic signed [15:0]            diff_y,
    output logic signed [15:0]            diff_z,
    output logic [7:0]                    calib_status
);
    import gfr_pkg::*;

    logic               good;
    logic [ANGLE_W-1:0] prev_reg, prev_next;
    logic [31:0]        odo_reg, odo_next;
    logic [2:0][15:0]   now_reg, now_next;
    logic [2:0][15:0]   off_reg, off_next;
    logic [2:0][15:0]   frame_accel;
    logic [2:0][15:0]   diff_calc;
    logic               valid_reg;

    // result registers
    logic               ok_reg;
    logic [7:0]         tag_reg, calib_reg;
    logic [15:0]        rate_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [31:0]        odo_out_reg;
    logic [2:0][15:0]   accel_reg, diff_reg;

    assign good = frame.done && frame.sum_ok;

    assign frame_accel[0] = 16'h0 - {payload[8], payload[7]};
    assign frame_accel[1] = {payload[6], payload[5]};
    assign frame_accel[2] = 16'h0 - {payload[10], payload[9]};

    always_comb
    begin
        prev_next = prev_reg;
        odo_next  = odo_reg;
        now_next  = now_reg;
        off_next  = off_reg;
        if (cmd.rezero)
        begin
            odo_next = '0;
            off_next = now_reg;
        end
        else if (cmd.arm)
        begin
            off_next = {3{OFFSET_ARMED}};
        end
        else if (good)
        begin
            prev_next = angle;
            odo_next  = odo_reg + {20'h0, angle} - {20'h0, prev_reg};
            now_next  = frame_accel;
            for (int k = 0; k < 3; k++)
            begin
                if (off_reg[k] == OFFSET_ARMED)
                begin
                    off_next[k] = frame_accel[k];
                end
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            diff_calc[k] = frame_accel[k] - off_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            odo_reg   <= '0;
            now_reg   <= '0;
            off_reg   <= {3{OFFSET_ARMED}};
            valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg <= prev_next;
            odo_reg  <= odo_next;
            now_reg  <= now_next;
            off_reg  <= off_next;
            if (frame.done)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // failed check gives all-zero fields
    always_ff @(posedge clk)
    begin
        if (frame.done)
        begin
            ok_reg      <= frame.sum_ok;
            tag_reg     <= good ? payload[0] : 8'h0;
            rate_reg    <= good ? 16'h0 - {payload[4], payload[3]} : 16'h0;
            angle_reg   <= good ? angle : '0;
            odo_out_reg <= good ? odo_next : 32'h0;
            accel_reg   <= good ? frame_accel : '0;
            diff_reg    <= good ? diff_calc : '0;
            calib_reg   <= good ? payload[11] : 8'h0;
        end
    end

    assign out_valid    = valid_reg;
    assign checksum_ok  = ok_reg;
    assign frame_tag    = tag_reg;
    assign rate         = rate_reg;
    assign angle_tenths = angle_reg;
    assign odometer     = odo_out_reg;
    assign accel_x      = accel_reg[0];
    assign accel_y      = accel_reg[1];
    assign accel_z      = accel_reg[2];
    assign diff_x       = diff_reg[0];
    assign diff_y       = diff_reg[1];
    assign diff_z       = diff_reg[2];
    assign calib_status = calib_reg;

endmodule

@@ rtl/gyro_frame_receiver.sv @@
// ============================================================================
// gyro_frame_receiver - gyro sensor frame receiver, top level
// Takes one received word per cycle unless stalled; returns one decoded result per frame.
// ============================================================================
// A word is taken in each unstalled cycle (one per cycle sustained). A frame is
// the sync pair 0xAA, 0x00 followed by 12 payload words and a check word;
// the check word's cycle writes one result into the output register, which
// carries checksum_ok and, when the sum matched, the decoded rate, heading,
// odometer, accelerations and offset differences (all zero otherwise).
// in_stall rises only when the check word is next and the previous result
// is still held by out_stall, and then blocks commands too; all other words
// are taken even while a result waits. Commands: 1 clears the odometer and
// copies the last accelerations into the offsets, 2 arms all three offsets so
// the next good frame latches them; command words yield no result.
// ============================================================================
module gyro_frame_receiver
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          checksum_ok,
    output logic [7:0]                    frame_tag,
    output logic signed [15:0]            rate,
    output logic [gfr_pkg::ANGLE_W-1:0]   angle_tenths,
    output logic signed [31:0]            odometer,
    output logic signed [15:0]            accel_x,
    output logic signed [15:0]            accel_y,
    output logic signed [15:0]            accel_z,
    output logic signed [15:0]            diff_x,
    output logic signed [15:0]            diff_y,
    output logic signed [15:0]            diff_z,
    output logic [7:0]                    calib_status
);
    import gfr_pkg::*;

    logic               accept;
    gfr_payload_t       payload;
    gfr_frame_t         frame;
    gfr_cmd_t           cmd;
    logic [ANGLE_W-1:0] angle;

    // hold off only when a new result would overwrite one still waiting
    assign in_stall = frame.at_last && out_valid && out_stall;
    assign accept   = in_valid && !in_stall;

    assign cmd.rezero = accept && (command == CMD_REZERO);
    assign cmd.arm    = accept && (command == CMD_ARM);

    gfr_deframer u_deframer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (command),
        .rx_byte (rx_byte),
        .payload (payload),
        .frame   (frame)
    );

    // heading pipeline runs off the stored words 1 and 2
    gfr_angle u_angle
    (
        .clk     (clk),
        .payload (payload),
        .angle   (angle)
    );

    gfr_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame        (frame),
        .cmd          (cmd),
        .payload      (payload),
        .angle        (angle),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .checksum_ok  (checksum_ok),
        .frame_tag    (frame_tag),
        .rate         (rate),
        .angle_tenths (angle_tenths),
        .odometer     (odometer),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .diff_x       (diff_x),
        .diff_y       (diff_y),
        .diff_z       (diff_z),
        .calib_status (calib_status)
    );

endmodule

@@ rtl/gfr_checker.sv @@
// ============================================================================
// gfr_checker - port-level checks for the gyro frame receiver
// Watches the handshakes and result fields; bound to the top level.
// ============================================================================
module gfr_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          checksum_ok,
    input logic [gfr_pkg::ANGLE_W-1:0]   angle_tenths,
    input logic signed [31:0]            odometer,
    input logic signed [15:0]            rate,
    input logic [7:0]                    frame_tag
);
    import gfr_pkg::*;

    // a held result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a held result does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(odometer) && $stable(angle_tenths))
        else $error("result changed while stalled");

    // input is held off only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with no result waiting");

    // failed frames carry zero fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !checksum_ok |-> odometer == 0 && rate == 0 &&
                                      angle_tenths == 0 && frame_tag == 0)
        else $error("failed frame with nonzero fields");

    // heading range
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && checksum_ok |-> angle_tenths <= ANGLE_W'(3599))
        else $error("heading out of range");

endmodule

bind gyro_frame_receiver gfr_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .checksum_ok  (checksum_ok),
    .angle_tenths (angle_tenths),
    .odometer     (odometer),
    .rate         (rate),
    .frame_tag    (frame_tag)
);
